// ===== hdl/ssh_pkg.sv =====
// Shared constants, types and state codes of the sample set statistics block.
`timescale 1ns / 1ps
package ssh_pkg;

  localparam int SetSize   = 64;
  localparam int SampleW   = 10;
  localparam int NumBins   = 8;
  localparam int AddrW     = $clog2(SetSize);
  localparam int CountW    = AddrW + 1;
  localparam int SumW      = SampleW + AddrW;
  localparam int BinW      = $clog2(NumBins);
  localparam int SqW       = 2 * SampleW;
  localparam int AccW      = SqW + AddrW;
  localparam int RemW      = SampleW + 2;
  localparam int StepW     = $clog2(SampleW);
  localparam int ThrW      = SampleW + 1;
  localparam int QueueDepth = 2;
  localparam int QPtrW     = $clog2(QueueDepth);

  typedef struct packed {
    logic [SampleW-1:0] mn;
    logic [SampleW-1:0] mx;
    logic [SumW-1:0]    sum;
  } job_t;

  typedef enum logic [2:0] {
    BackIdle,
    BackVar,
    BackRoot,
    BackHist,
    BackEmit
  } back_state_e;

endpackage

// ===== hdl/sample_set_statistics_histogram_top.sv =====
// Top level of the sample set statistics and histogram block.
`timescale 1ns / 1ps
// Usage: samples enter one beat at a time on the in channel (in_valid_i,
// in_ready_o, sample_i). Each beat is written to the sample store while
// the front end keeps the running minimum, maximum and sum.
// The beat that completes a set of 64 hands a descriptor to the back end
// through a two-entry queue, and the front end then holds in_ready_o low
// until the back end has finished reading the store for that set.
// The back end makes one pass over the store to sum the squared deviations
// (one read per cycle), runs a digit-by-digit square root (one result bit
// per cycle), then makes a second pass to build the histogram. It then
// offers eight beats on the out channel, one per bin, the last one flagged
// by last_o.
// The rate at which sets are taken is set by the two read passes through
// the single read port of the store.
// The next set may be loaded while the results are still being delivered.
// When the receiver stalls, the output register holds its beat and the
// back end waits; the front end carries on until its next set is complete.
// Reset empties the queue, clears the counters and running values and
// drops out_valid_o; the sample store itself is not cleared.
module sample_set_statistics_histogram_top import ssh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] minimum_o,
  output logic [SampleW-1:0] maximum_o,
  output logic [SampleW-1:0] average_o,
  output logic [SampleW-1:0] spread_o,
  output logic [SampleW-1:0] deviation_o,
  output logic [BinW-1:0]    bin_index_o,
  output logic [CountW-1:0]  bin_count_o,
  output logic               last_o
);
  logic               we, push, q_full, q_valid, pop, store_free;
  logic [AddrW-1:0]   waddr, raddr;
  logic [SampleW-1:0] wdata, rdata;
  job_t               job_in, job_out;

  // Front end: loading and running statistics.
  ssh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .store_free_i (store_free),
    .q_full_i     (q_full),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .push_o       (push),
    .job_o        (job_in)
  );

  // The sample store, written by the front end and read by the back end.
  ssh_ram #(
    .Width (SampleW),
    .Depth (SetSize)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Descriptors of completed sets wait here for the back end.
  ssh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (job_out)
  );

  // Back end: deviation, root, histogram and result beats.
  ssh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_i        (job_out),
    .pop_o        (pop),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .store_free_o (store_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .minimum_o    (minimum_o),
    .maximum_o    (maximum_o),
    .average_o    (average_o),
    .spread_o     (spread_o),
    .deviation_o  (deviation_o),
    .bin_index_o  (bin_index_o),
    .bin_count_o  (bin_count_o),
    .last_o       (last_o)
  );
endmodule

// ===== hdl/ssh_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module ssh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/ssh_front.sv =====
// Front end: takes samples, stores them and tracks minimum, maximum and sum.
`timescale 1ns / 1ps
module ssh_front import ssh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_i,
  input  logic               store_free_i,
  input  logic               q_full_i,
  output logic               we_o,
  output logic [AddrW-1:0]   waddr_o,
  output logic [SampleW-1:0] wdata_o,
  output logic               push_o,
  output job_t               job_o
);
  logic [AddrW-1:0]   fill_q, fill_d;
  logic [SampleW-1:0] mn_q, mn_d, mn_new;
  logic [SampleW-1:0] mx_q, mx_d, mx_new;
  logic [SumW-1:0]    sum_q, sum_d, sum_new;
  logic               busy_q, busy_d;
  logic               last, acc;

  assign last       = (fill_q == AddrW'(SetSize - 1));
  assign in_ready_o = !busy_q && !(last && q_full_i);
  assign acc        = in_valid_i && in_ready_o;
  assign mn_new     = (sample_i < mn_q) ? sample_i : mn_q;
  assign mx_new     = (sample_i > mx_q) ? sample_i : mx_q;
  assign sum_new    = sum_q + SumW'(sample_i);

  assign we_o    = acc;
  assign waddr_o = fill_q;
  assign wdata_o = sample_i;
  assign push_o  = acc && last;
  assign job_o   = '{mn: mn_new, mx: mx_new, sum: sum_new};

  always_comb begin
    fill_d = fill_q;
    mn_d   = mn_q;
    mx_d   = mx_q;
    sum_d  = sum_q;
    busy_d = busy_q;
    if (store_free_i) begin
      busy_d = 1'b0;
    end
    if (acc) begin
      if (last) begin
        fill_d = '0;
        mn_d   = '1;
        mx_d   = '0;
        sum_d  = '0;
        busy_d = 1'b1;
      end else begin
        fill_d = fill_q + 1'b1;
        mn_d   = mn_new;
        mx_d   = mx_new;
        sum_d  = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      mn_q   <= '1;
      mx_q   <= '0;
      sum_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      mn_q   <= mn_d;
      mx_q   <= mx_d;
      sum_q  <= sum_d;
      busy_q <= busy_d;
    end
  end
endmodule

// ===== hdl/ssh_queue.sv =====
// Short queue of completed set descriptors between the front and back ends.
`timescale 1ns / 1ps
module ssh_queue import ssh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);
  job_t              entry_q [QueueDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QPtrW:0]    cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

// ===== hdl/ssh_back.sv =====
// Back end: variance pass, square root, histogram pass and result output.
`timescale 1ns / 1ps
module ssh_back import ssh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               pop_o,
  output logic [AddrW-1:0]   raddr_o,
  input  logic [SampleW-1:0] rdata_i,
  output logic               store_free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] minimum_o,
  output logic [SampleW-1:0] maximum_o,
  output logic [SampleW-1:0] average_o,
  output logic [SampleW-1:0] spread_o,
  output logic [SampleW-1:0] deviation_o,
  output logic [BinW-1:0]    bin_index_o,
  output logic [CountW-1:0]  bin_count_o,
  output logic               last_o
);
  back_state_e state_q, state_d;

  logic [SampleW-1:0] mn_q, mx_q, avg_q, spread_q, width_q, root_q;
  logic [SampleW-1:0] job_spread, job_width, delta, diff;
  logic [ThrW-1:0]    thr_q [NumBins-1];
  logic [CountW-1:0]  issue_q;
  logic               rv_q, sv_q;
  logic [SqW-1:0]     sq_q, v_q;
  logic [AccW-1:0]    acc_q;
  logic [RemW-1:0]    rem_q;
  logic [RemW+1:0]    rem_sh, trial;
  logic [StepW-1:0]   step_q;
  logic [CountW-1:0]  bins_q [NumBins];
  logic [BinW-1:0]    emit_q, bin;
  logic               issuing, reads_done, load;

  logic               ov_q;
  logic [SampleW-1:0] o_mn_q, o_mx_q, o_avg_q, o_spr_q, o_dev_q;
  logic [BinW-1:0]    o_idx_q;
  logic [CountW-1:0]  o_cnt_q;
  logic               o_last_q;

  assign job_spread = job_i.mx - job_i.mn;
  assign job_width  = SampleW'((ThrW'(job_spread) + ThrW'(NumBins - 1)) >> BinW);
  assign issuing    = (state_q == BackVar || state_q == BackHist) &&
                      (issue_q != CountW'(SetSize));
  assign reads_done = (issue_q == CountW'(SetSize)) && !rv_q && !sv_q;
  assign raddr_o    = issue_q[AddrW-1:0];
  assign delta      = (rdata_i >= avg_q) ? rdata_i - avg_q : avg_q - rdata_i;
  assign diff       = rdata_i - mn_q;
  assign rem_sh     = {rem_q, v_q[SqW-1 -: 2]};
  assign trial      = (RemW+2)'({root_q, 2'b01});
  assign load       = (state_q == BackEmit) && (!ov_q || out_ready_i);

  always_comb begin
    bin = '0;
    for (int k = 1; k < NumBins; k++) begin
      if (ThrW'(diff) >= thr_q[k-1]) begin
        bin = bin + 1'b1;
      end
    end
    if (width_q == '0) begin
      bin = '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    pop_o        = 1'b0;
    store_free_o = 1'b0;
    case (state_q)
      BackIdle: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          state_d = BackVar;
        end
      end
      BackVar: begin
        if (reads_done) begin
          state_d = BackRoot;
        end
      end
      BackRoot: begin
        if (step_q == '0) begin
          state_d = BackHist;
        end
      end
      BackHist: begin
        if (reads_done) begin
          store_free_o = 1'b1;
          state_d      = BackEmit;
        end
      end
      BackEmit: begin
        if (load && emit_q == BinW'(NumBins - 1)) begin
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
      rv_q    <= 1'b0;
      sv_q    <= 1'b0;
      issue_q <= '0;
      ov_q    <= 1'b0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      rv_q    <= issuing;
      sv_q    <= rv_q && (state_q == BackVar);
      if (pop_o || (state_q == BackRoot && step_q == '0)) begin
        issue_q <= '0;
      end else if (issuing) begin
        issue_q <= issue_q + 1'b1;
      end
      if (store_free_o) begin
        emit_q <= '0;
      end else if (load) begin
        emit_q <= emit_q + 1'b1;
      end
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mn_q     <= job_i.mn;
      mx_q     <= job_i.mx;
      avg_q    <= SampleW'(job_i.sum >> AddrW);
      spread_q <= job_spread;
      width_q  <= job_width;
      acc_q    <= '0;
    end
    if (state_q == BackVar) begin
      for (int k = 1; k < NumBins; k++) begin
        thr_q[k-1] <= ThrW'(ThrW'(width_q) * ThrW'(k));
      end
      if (rv_q) begin
        sq_q <= SqW'(delta) * SqW'(delta);
      end
      if (sv_q) begin
        acc_q <= acc_q + AccW'(sq_q);
      end
      if (reads_done) begin
        v_q    <= SqW'(acc_q >> AddrW);
        root_q <= '0;
        rem_q  <= '0;
        step_q <= StepW'(SampleW - 1);
      end
    end
    if (state_q == BackRoot) begin
      if (rem_sh >= trial) begin
        rem_q  <= RemW'(rem_sh - trial);
        root_q <= {root_q[SampleW-2:0], 1'b1};
      end else begin
        rem_q  <= RemW'(rem_sh);
        root_q <= {root_q[SampleW-2:0], 1'b0};
      end
      v_q    <= {v_q[SqW-3:0], 2'b00};
      step_q <= step_q - 1'b1;
      if (step_q == '0) begin
        for (int k = 0; k < NumBins; k++) begin
          bins_q[k] <= '0;
        end
      end
    end
    if (state_q == BackHist && rv_q) begin
      bins_q[bin] <= bins_q[bin] + 1'b1;
    end
    if (load) begin
      o_mn_q   <= mn_q;
      o_mx_q   <= mx_q;
      o_avg_q  <= avg_q;
      o_spr_q  <= spread_q;
      o_dev_q  <= root_q;
      o_idx_q  <= emit_q;
      o_cnt_q  <= bins_q[emit_q];
      o_last_q <= (emit_q == BinW'(NumBins - 1));
    end
  end

  assign out_valid_o = ov_q;
  assign minimum_o   = o_mn_q;
  assign maximum_o   = o_mx_q;
  assign average_o   = o_avg_q;
  assign spread_o    = o_spr_q;
  assign deviation_o = o_dev_q;
  assign bin_index_o = o_idx_q;
  assign bin_count_o = o_cnt_q;
  assign last_o      = o_last_q;
endmodule

// ===== tb/sv/tb_sample_set_statistics_histogram_top.sv =====
// Testbench for the sample set statistics and histogram block.
`timescale 1ns / 1ps
module tb_sample_set_statistics_histogram_top;
  import ssh_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [SampleW-1:0] mn;
    logic [SampleW-1:0] mx;
    logic [SampleW-1:0] avg;
    logic [SampleW-1:0] spr;
    logic [SampleW-1:0] dev;
    logic [BinW-1:0]    idx;
    logic [CountW-1:0]  cnt;
    logic               lst;
  } bin_report_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [SampleW-1:0] sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [SampleW-1:0] minimum_o;
  logic [SampleW-1:0] maximum_o;
  logic [SampleW-1:0] average_o;
  logic [SampleW-1:0] spread_o;
  logic [SampleW-1:0] deviation_o;
  logic [BinW-1:0]    bin_index_o;
  logic [CountW-1:0]  bin_count_o;
  logic               last_o;

  sample_set_statistics_histogram_top dut (.*);

  // Predictor state: the samples of the set being filled.
  logic [SampleW-1:0] set_samples[SetSize];
  int                 set_fill;
  bin_report_t        expected_bins[$];
  int                 failures;
  int                 cycles;
  int                 burst_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Integer square root, rounded down, by bisection.
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = '0;
    hi = 64'd1 << 20;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Take in one accepted sample; on the last of a set, queue the eight bins.
  task automatic predict_histogram(input logic [SampleW-1:0] s);
    int unsigned     mn, mx, sum, avg, spr, width, b, d;
    longint unsigned sq;
    int unsigned     counts[NumBins];
    bin_report_t     r;
    set_samples[set_fill] = s;
    set_fill++;
    if (set_fill < SetSize) return;
    set_fill = 0;
    mn = (1 << SampleW) - 1;
    mx = 0;
    sum = 0;
    sq = 0;
    for (int i = 0; i < SetSize; i++) begin
      if (set_samples[i] < mn) mn = set_samples[i];
      if (set_samples[i] > mx) mx = set_samples[i];
      sum += set_samples[i];
    end
    avg = sum / SetSize;
    spr = mx - mn;
    for (int i = 0; i < SetSize; i++) begin
      d = (set_samples[i] >= avg) ? set_samples[i] - avg : avg - set_samples[i];
      sq += longint'(d) * d;
    end
    width = (spr + NumBins - 1) / NumBins;
    foreach (counts[i]) counts[i] = 0;
    for (int i = 0; i < SetSize; i++) begin
      // With no spread every sample lands in the bottom bin; past the top it clamps.
      b = (width == 0) ? 0 : (set_samples[i] - mn) / width;
      if (b > NumBins - 1) b = NumBins - 1;
      counts[b]++;
    end
    for (int i = 0; i < NumBins; i++) begin
      r.mn  = SampleW'(mn);
      r.mx  = SampleW'(mx);
      r.avg = SampleW'(avg);
      r.spr = SampleW'(spr);
      r.dev = SampleW'(int_root(sq / SetSize));
      r.idx = BinW'(i);
      r.cnt = CountW'(counts[i]);
      r.lst = (i == NumBins - 1);
      expected_bins.push_back(r);
    end
  endtask

  // Send one sample beat, with the sender working in bursts, most of them separated by gaps.
  task automatic send_sample(input logic [SampleW-1:0] s);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predict_histogram(s);
  endtask

  // Receiver stalls on a pattern of its own: quiet spells and busy spells.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if ((cycles / 500) % 3 == 0) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker: each accepted beat against the oldest expected bin.
  initial begin
    bin_report_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_bins.size() == 0) begin
          $error("result beat with nothing expected");
          failures++;
        end else begin
          e = expected_bins.pop_front();
          if (minimum_o !== e.mn) begin
            $error("minimum: expected %0d, actual %0d", e.mn, minimum_o); failures++;
          end
          if (maximum_o !== e.mx) begin
            $error("maximum: expected %0d, actual %0d", e.mx, maximum_o); failures++;
          end
          if (average_o !== e.avg) begin
            $error("average: expected %0d, actual %0d", e.avg, average_o); failures++;
          end
          if (spread_o !== e.spr) begin
            $error("spread: expected %0d, actual %0d", e.spr, spread_o); failures++;
          end
          if (deviation_o !== e.dev) begin
            $error("deviation: expected %0d, actual %0d", e.dev, deviation_o); failures++;
          end
          if (bin_index_o !== e.idx) begin
            $error("bin_index: expected %0d, actual %0d", e.idx, bin_index_o); failures++;
          end
          if (bin_count_o !== e.cnt) begin
            $error("bin_count: expected %0d, actual %0d", e.cnt, bin_count_o); failures++;
          end
          if (last_o !== e.lst) begin
            $error("last: expected %0d, actual %0d", e.lst, last_o); failures++;
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Extremes: a set with no spread at the top of the range, and one that
  // alternates between both ends.
  task automatic test_extremes();
    repeat (SetSize) send_sample('1);
    for (int i = 0; i < SetSize; i++) send_sample(i[0] ? '1 : '0);
  endtask

  // A spread that is a whole multiple of the bin count, so the maximum falls
  // one past the top bin and clamps.
  task automatic test_clamped_bins();
    for (int i = 0; i < SetSize; i++) send_sample(SampleW'(300 + (i % 17)));
  endtask

  // A random set clustered around a random centre with a random reach.
  task automatic test_random_set();
    int unsigned centre, reach, lo, hi;
    centre = $urandom_range(0, 1023);
    reach  = $urandom_range(0, 1023);
    lo = (centre > reach) ? centre - reach : 0;
    hi = (centre + reach > 1023) ? 1023 : centre + reach;
    repeat (SetSize) send_sample(SampleW'($urandom_range(lo, hi)));
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    sample_i   = '0;
    failures   = 0;
    set_fill   = 0;
    burst_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_clamped_bins();
    test_random_set();
    in_valid_i <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (failures == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== sample_set_statistics_histogram_top.f =====
hdl/ssh_pkg.sv
hdl/ssh_ram.sv
hdl/ssh_front.sv
hdl/ssh_queue.sv
hdl/ssh_back.sv
hdl/sample_set_statistics_histogram_top.sv
tb/sv/tb_sample_set_statistics_histogram_top.sv
